// ===== sv/crcfpr_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfpr_pkg
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the
// framed packet receiver.
// ----------------------------------------------------------------------------
package crcfpr_pkg;

  localparam logic [7:0]  SYNC_HI_MASK = 8'hC0;
  localparam logic [7:0]  SYNC_HI_VAL  = 8'hC0;
  localparam logic [7:0]  SYNC_LO_MASK = 8'h03;
  localparam logic [7:0]  SYNC_LO_VAL  = 8'h01;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;

  typedef enum logic [2:0] {
    STAT_INCOMPLETE = 3'd0,
    STAT_OK         = 3'd1,
    STAT_SYNC_ERR   = 3'd2,
    STAT_LEN_ERR    = 3'd3,
    STAT_CRC_ERR    = 3'd4
  } status_e;

  typedef struct packed {
    status_e    status;
    logic [7:0] control_byte;
    logic [7:0] dest_address;
    logic [7:0] payload_byte;
    logic [4:0] byte_position;
    logic [5:0] frame_length;
    logic       last;
  } result_t;

  typedef struct packed {
    logic    push;
    logic    sync_ld;
    logic    addr_ld;
    logic    len_ld;
    logic    body_wr;
    logic    crc_lo_ld;
    logic    emit_sel;
    logic    emit_step;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic sync_ok;
    logic len_ok;
    logic body_last;
    logic crc_match;
    logic emit_last;
  } dp_stat_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== sv/crcfpr_obuf.sv =====
// ----------------------------------------------------------------------------
// crcfpr_obuf
// Two-entry result buffer between the receiver core and the output stream.
// ----------------------------------------------------------------------------
module crcfpr_obuf import crcfpr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_valid_i,
  output logic    wr_ready_o,
  input  result_t wr_data_i,
  output logic    rd_valid_o,
  input  logic    rd_ready_i,
  output result_t rd_data_o
);

  logic [1:0] cnt_q;
  logic       wp_q;
  logic       rp_q;
  result_t    ent_q [2];
  logic       wr;
  logic       rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = ent_q[rp_q];
  assign wr         = wr_valid_i && wr_ready_o;
  assign rd         = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
      if (wr) begin
        wp_q <= ~wp_q;
      end
      if (rd) begin
        rp_q <= ~rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      ent_q[wp_q] <= wr_data_i;
    end
  end

endmodule

// ===== sv/crcfpr_datapath.sv =====
// ----------------------------------------------------------------------------
// crcfpr_datapath
// Header registers, running CRC, payload memory and burst counter; forms one
// result per push.
// ----------------------------------------------------------------------------
module crcfpr_datapath import crcfpr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] data_byte_i,
  input  cmd_t       cmd_i,
  output dp_stat_t   stat_o,
  output result_t    res_o
);

  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]    ctrl_q;
  logic [7:0]    addr_q;
  logic [CW-1:0] len_q;
  logic [CW-1:0] fill_q;
  logic [7:0]    crc_lo_q;
  logic [15:0]   crc_q;
  logic [AW-1:0] emit_q;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_q;
  logic [7:0]    mem_q [MAX_PAYLOAD];

  assign stat_o.sync_ok   = ((data_byte_i & SYNC_HI_MASK) == SYNC_HI_VAL) &&
                            ((data_byte_i & SYNC_LO_MASK) == SYNC_LO_VAL);
  assign stat_o.len_ok    = (data_byte_i != 8'h00) && (data_byte_i <= 8'(MAX_PAYLOAD));
  assign stat_o.body_last = ((fill_q + CW'(1)) == len_q);
  assign stat_o.crc_match = ({data_byte_i, crc_lo_q} == crc_q);
  assign stat_o.emit_last = ((CW'(emit_q) + CW'(1)) == len_q);

  always_comb begin
    if (cmd_i.emit_step) begin
      rd_addr = stat_o.emit_last ? '0 : emit_q + AW'(1);
    end else begin
      rd_addr = emit_q;
    end
  end

  always_comb begin
    res_o = '0;
    if (cmd_i.emit_sel) begin
      res_o.status        = STAT_OK;
      res_o.control_byte  = ctrl_q;
      res_o.dest_address  = addr_q;
      res_o.payload_byte  = rd_q;
      res_o.byte_position = 5'(emit_q);
      res_o.frame_length  = 6'(len_q);
      res_o.last          = stat_o.emit_last;
    end else begin
      res_o.status = cmd_i.status;
      res_o.last   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q   <= 8'h00;
      addr_q   <= 8'h00;
      len_q    <= '0;
      fill_q   <= '0;
      crc_lo_q <= 8'h00;
      crc_q    <= CRC_INIT;
      emit_q   <= '0;
    end else begin
      if (cmd_i.sync_ld) begin
        ctrl_q <= data_byte_i;
        crc_q  <= crc16_byte(CRC_INIT, data_byte_i);
      end
      if (cmd_i.addr_ld) begin
        addr_q <= data_byte_i;
        crc_q  <= crc16_byte(crc_q, data_byte_i);
      end
      if (cmd_i.len_ld) begin
        len_q  <= data_byte_i[CW-1:0];
        fill_q <= '0;
        crc_q  <= crc16_byte(crc_q, data_byte_i);
      end
      if (cmd_i.body_wr) begin
        fill_q <= fill_q + CW'(1);
        crc_q  <= crc16_byte(crc_q, data_byte_i);
      end
      if (cmd_i.crc_lo_ld) begin
        crc_lo_q <= data_byte_i;
      end
      if (cmd_i.emit_step) begin
        emit_q <= rd_addr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.body_wr) begin
      mem_q[fill_q[AW-1:0]] <= data_byte_i;
    end
    rd_q <= mem_q[rd_addr];
  end

endmodule

// ===== sv/crcfpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// crcfpr_ctrl
// Frame parsing state machine; issues datapath commands and result pushes.
// ----------------------------------------------------------------------------
module crcfpr_ctrl import crcfpr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  output logic     s_tready_o,
  input  logic     buf_ready_i,
  input  dp_stat_t stat_i,
  output cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    S_SEEK,
    S_ADDR,
    S_LEN,
    S_BODY,
    S_CRC_LO,
    S_CRC_HI,
    S_EMIT
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   acc;

  assign s_tready_o = (state_q != S_EMIT) && buf_ready_i;
  assign acc        = s_tvalid_i && s_tready_o;

  always_comb begin
    cmd_o        = '0;
    cmd_o.status = STAT_INCOMPLETE;
    state_d      = state_q;
    case (state_q)
      S_SEEK: begin
        if (acc) begin
          cmd_o.push = 1'b1;
          if (stat_i.sync_ok) begin
            cmd_o.sync_ld = 1'b1;
            state_d       = S_ADDR;
          end else begin
            cmd_o.status = STAT_SYNC_ERR;
          end
        end
      end
      S_ADDR: begin
        if (acc) begin
          cmd_o.push    = 1'b1;
          cmd_o.addr_ld = 1'b1;
          state_d       = S_LEN;
        end
      end
      S_LEN: begin
        if (acc) begin
          cmd_o.push = 1'b1;
          if (stat_i.len_ok) begin
            cmd_o.len_ld = 1'b1;
            state_d      = S_BODY;
          end else begin
            cmd_o.status = STAT_LEN_ERR;
            state_d      = S_SEEK;
          end
        end
      end
      S_BODY: begin
        if (acc) begin
          cmd_o.push    = 1'b1;
          cmd_o.body_wr = 1'b1;
          if (stat_i.body_last) begin
            state_d = S_CRC_LO;
          end
        end
      end
      S_CRC_LO: begin
        if (acc) begin
          cmd_o.push      = 1'b1;
          cmd_o.crc_lo_ld = 1'b1;
          state_d         = S_CRC_HI;
        end
      end
      S_CRC_HI: begin
        if (acc) begin
          if (stat_i.crc_match) begin
            state_d = S_EMIT;
          end else begin
            cmd_o.push   = 1'b1;
            cmd_o.status = STAT_CRC_ERR;
            state_d      = S_SEEK;
          end
        end
      end
      S_EMIT: begin
        cmd_o.emit_sel = 1'b1;
        cmd_o.status   = STAT_OK;
        if (buf_ready_i) begin
          cmd_o.push      = 1'b1;
          cmd_o.emit_step = 1'b1;
          if (stat_i.emit_last) begin
            state_d = S_SEEK;
          end
        end
      end
      default: begin
        state_d = S_SEEK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SEEK;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_input_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> !s_tready_o) else $error("input taken during burst");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> buf_ready_i) else $error("push into full buffer");

  a_match_starts_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CRC_HI && acc && stat_i.crc_match) |=> (state_q == S_EMIT))
    else $error("crc match did not start burst");

  a_burst_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && buf_ready_i && stat_i.emit_last) |=> (state_q == S_SEEK))
    else $error("burst did not end on last byte");

endmodule

// ===== sv/crc_framed_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// crc_framed_packet_receiver
// Parses control/address/length/payload/CRC frames from a byte stream and
// emits the payload of each frame whose CRC-16/CCITT-FALSE matches.
// ----------------------------------------------------------------------------
// Timing: a result is registered in the output buffer before it appears on the
//   master side; the first payload result of a matching frame passes through
//   the S_EMIT state and then the output buffer after its high CRC byte.
// Throughput: one byte per cycle while the output buffer has room; a matching
//   frame then emits its length in results, one per cycle from the payload
//   memory while the buffer has room, and holds input off until the last is pushed.
// Reset: asynchronous; parser returns to sync hunt, CRC to 0xFFFF, buffer empty.
module crc_framed_packet_receiver import crcfpr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // control_byte, dest_address, payload_byte,
                                     // byte_position, frame_length, zero fill
  output logic [2:0]  m_axis_tuser,  // status
  output logic        m_axis_tlast   // last
);

  cmd_t     cmd;
  dp_stat_t dp_stat;
  result_t  res;
  result_t  out;
  logic     buf_ready;

  crcfpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .buf_ready_i (buf_ready),
    .stat_i      (dp_stat),
    .cmd_o       (cmd)
  );

  crcfpr_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (dp_stat),
    .res_o       (res)
  );

  crcfpr_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cmd.push),
    .wr_ready_o (buf_ready),
    .wr_data_i  (res),
    .rd_valid_o (m_axis_tvalid),
    .rd_ready_i (m_axis_tready),
    .rd_data_o  (out)
  );

  assign m_axis_tdata = {5'b00000, out.frame_length, out.byte_position,
                         out.payload_byte, out.dest_address, out.control_byte};
  assign m_axis_tuser = out.status;
  assign m_axis_tlast = out.last;

endmodule
